### hw/rtl/htw_pkg.sv
// shared types and constants of the hierarchical timer wheel
package htw_pkg;

  localparam int SLOTS = 256;
  localparam int MAX_REPORT = 32;
  localparam int ID_W = 6;
  localparam logic [ID_W-1:0] NIL = 6'h3F;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    K_ADD_OK  = 2'd0,
    K_ADD_REJ = 2'd1,
    K_EXPIRED = 2'd2,
    K_DONE    = 2'd3
  } kind_t;

endpackage

### hw/rtl/htw_ram.sv
// generic single-port-write, single-port-read ram with registered read
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/htw_div.sv
// radix-2 restoring divider, 32-bit dividend by 10-bit divisor
module htw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        run;
  logic [4:0]  cnt;
  logic [9:0]  rem;
  logic [9:0]  dsr;
  logic [10:0] trial;

  assign trial = {rem, quotient[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        if (trial >= {1'b0, dsr}) begin
          rem      <= 10'(trial - {1'b0, dsr});
          quotient <= {quotient[30:0], 1'b1};
        end else begin
          rem      <= trial[9:0];
          quotient <= {quotient[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/hierarchical_timer_wheel.sv
// top level: hierarchical timer wheel with slot lists kept in rams
//
// usage: an item is taken when start is high and busy is low. action 0
// adds timer timer_id with delay_ms (periodic re-arms it on expiry),
// action 1 reports one elapsed tick. results appear on kind, expired_id
// and last for one cycle under result_strobe; the receiver cannot stall.
// msec_per_tick is written through msec_per_tick_we; the user must
// write it only while busy is low, the block does not enforce it.
// an add gives one result after the 32-step serial divider, handoff,
// slot lookup and list append; an add with an id outside the pool is
// answered in the next cycle. a tick visits each due wheel from the
// highest down, reads and clears its slot and walks its list, moving
// timers down one wheel, or on wheel 0 reporting them and re-arming
// periodic ones; it ends with a tick-done result with last set.
// after reset the slot ram is swept empty, one entry a cycle, over all
// WHEELS*256 entries with busy high; the tick length resets to 1.
module hierarchical_timer_wheel
  import htw_pkg::*;
#(
  parameter int WHEELS     = 4,
  parameter int MAX_TIMERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [4:0]  timer_id,
  input  logic [31:0] delay_ms,
  input  logic        periodic,
  input  logic        msec_per_tick_we,
  input  logic [9:0]  msec_per_tick,
  output logic        result_strobe,
  output logic [1:0]  kind,
  output logic [4:0]  expired_id,
  output logic        last
);

  localparam int LW = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int SA = LW + 8;
  localparam int SD = WHEELS * SLOTS;
  localparam int PW = 8 * WHEELS;
  localparam int AW = ((PW > 32) ? PW : 32) + 1;
  localparam int TA = $clog2(MAX_TIMERS);
  localparam int TW = 33 + PW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ARM_A, S_ARM_B, S_ARM_C,
    S_LINK_RD, S_LINK, S_DSP_RD, S_DSP_CLR, S_WALK, S_WALK_D
  } state_t;

  state_t           state;
  logic [9:0]       tick_len;
  logic [7:0]       pos [WHEELS];
  logic [7:0]       pos_next [WHEELS];
  logic [LW-1:0]    lv, lv_start, lwm;
  logic [LW-1:0]    link_w;
  logic [7:0]       link_slot;
  logic [ID_W-1:0]  link_id, cur, steps, n_rep;
  logic             link_tw, ctx_tick;
  logic [31:0]      arm_delay;
  logic             arm_rep;
  logic [3:0]       arm_w, hb;
  logic [AW-1:0]    arm_adj, adj0, adj1, adj_sh;
  logic [PW-1:0]    adjv_a, adjv_b, rem_sh;
  logic             big;
  logic [7:0]       arm_slot, casc_slot;
  logic [SA-1:0]    clr_addr;
  logic [ID_W-1:0]  id_ext;

  logic             div_start, div_done;
  logic [31:0]      div_q, q_eff, div_dividend;

  logic             slot_we;
  logic [SA-1:0]    slot_waddr, slot_raddr;
  logic [11:0]      slot_wdata, slot_rdata;
  logic             nl_we;
  logic [TA-1:0]    nl_waddr, nl_raddr;
  logic [ID_W-1:0]  nl_wdata, nl_rdata;
  logic             tm_we;
  logic [TA-1:0]    tm_waddr, tm_raddr;
  logic [TW-1:0]    tm_wdata, tm_rdata;
  logic [31:0]      tm_delay;
  logic             tm_rep;
  logic [PW-1:0]    tm_rem;
  logic [ID_W-1:0]  s_head, s_tail;

  assign busy     = (state != S_IDLE);
  assign id_ext   = {1'b0, timer_id};
  assign tm_delay = tm_rdata[TW-1 -: 32];
  assign tm_rep   = tm_rdata[PW];
  assign tm_rem   = tm_rdata[PW-1:0];
  assign s_head   = slot_rdata[11:6];
  assign s_tail   = slot_rdata[5:0];
  assign q_eff    = (div_q == 32'd0) ? 32'd1 : div_q;

  // position carry chain and first wheel to dispatch
  always_comb begin
    logic carry;
    int   cnt;
    carry = 1'b1;
    cnt   = 0;
    for (int k = 0; k < WHEELS; k++) begin
      pos_next[k] = carry ? 8'(pos[k] + 8'd1) : pos[k];
      if (carry && pos[k] == 8'hFF && k < WHEELS - 1) begin
        cnt = k + 1;
      end else begin
        carry = 1'b0;
      end
    end
    lv_start = LW'(cnt);
  end

  // arm arithmetic
  always_comb begin
    hb = '0;
    for (int i = 0; i < 4; i++) begin
      if (q_eff[8*i +: 8] != 8'd0) begin
        hb = 4'(i);
      end
    end
    adjv_a = '0;
    adjv_b = '0;
    for (int i = 0; i < WHEELS; i++) begin
      if (i < int'(hb)) begin
        adjv_a[8*i +: 8] = pos[i];
      end
      if (i < int'(arm_w) + 1) begin
        adjv_b[8*i +: 8] = pos[i];
      end
    end
    adj0     = AW'(q_eff) + AW'(adjv_a);
    adj1     = AW'(q_eff) + AW'(adjv_b);
    big      = ((arm_adj >> (8 * (int'(arm_w) + 1))) != '0);
    adj_sh   = arm_adj >> (8 * int'(arm_w));
    arm_slot = 8'(adj_sh[7:0] + pos[arm_w[LW-1:0]]);
    lwm      = LW'(lv - 1'b1);
    rem_sh   = tm_rem >> (8 * int'(lwm));
    casc_slot = 8'(rem_sh[7:0] + pos[lwm]);
  end

  assign div_start = (state == S_IDLE && start && action == ACT_ADD &&
                      id_ext < ID_W'(MAX_TIMERS)) ||
                     (state == S_WALK_D && lv == '0 && tm_rep);
  assign div_dividend = (state == S_IDLE) ? delay_ms : tm_delay;

  htw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ((tick_len == 10'd0) ? 10'd1 : tick_len),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = {NIL, NIL};
    slot_raddr = '0;
    nl_we      = 1'b0;
    nl_waddr   = '0;
    nl_wdata   = NIL;
    nl_raddr   = '0;
    tm_we      = 1'b0;
    tm_waddr   = '0;
    tm_wdata   = {arm_delay, arm_rep, arm_adj[PW-1:0]};
    tm_raddr   = '0;
    case (state)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_addr;
      end
      S_LINK_RD: begin
        slot_raddr = {link_w, link_slot};
        nl_we      = 1'b1;
        nl_waddr   = link_id[TA-1:0];
        tm_we      = link_tw;
        tm_waddr   = link_id[TA-1:0];
      end
      S_LINK: begin
        slot_we    = 1'b1;
        slot_waddr = {link_w, link_slot};
        if (s_head == NIL || s_tail >= ID_W'(MAX_TIMERS)) begin
          slot_wdata = {link_id, link_id};
        end else begin
          slot_wdata = {s_head, link_id};
          nl_we      = 1'b1;
          nl_waddr   = s_tail[TA-1:0];
          nl_wdata   = link_id;
        end
      end
      S_DSP_RD: begin
        slot_raddr = {lv, pos[lv]};
      end
      S_DSP_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = {lv, pos[lv]};
      end
      S_WALK: begin
        nl_raddr = cur[TA-1:0];
        tm_raddr = cur[TA-1:0];
      end
      default: begin
      end
    endcase
  end

  htw_ram #(.WIDTH(12), .DEPTH(1 << SA)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  htw_ram #(.WIDTH(ID_W), .DEPTH(MAX_TIMERS)) u_link_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  htw_ram #(.WIDTH(TW), .DEPTH(MAX_TIMERS)) u_timer_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .raddr (tm_raddr),
    .rdata (tm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      tick_len      <= 10'd1;
      for (int k = 0; k < WHEELS; k++) begin
        pos[k] <= 8'd0;
      end
      result_strobe <= 1'b0;
      kind          <= K_ADD_OK;
      expired_id    <= '0;
      last          <= 1'b0;
      n_rep         <= '0;
      steps         <= '0;
      lv            <= '0;
      ctx_tick      <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (msec_per_tick_we) begin
        tick_len <= msec_per_tick;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SA'(SD - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            arm_delay <= delay_ms;
            arm_rep   <= periodic;
            link_id   <= id_ext;
            link_tw   <= 1'b1;
            if (action == ACT_ADD) begin
              ctx_tick <= 1'b0;
              if (id_ext >= ID_W'(MAX_TIMERS)) begin
                result_strobe <= 1'b1;
                kind          <= K_ADD_REJ;
                expired_id    <= timer_id;
                last          <= 1'b1;
              end else begin
                state <= S_DIV;
              end
            end else begin
              ctx_tick <= 1'b1;
              pos      <= pos_next;
              lv       <= lv_start;
              n_rep    <= '0;
              state    <= S_DSP_RD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_ARM_A;
          end
        end
        S_ARM_A: begin
          arm_w   <= hb;
          arm_adj <= adj0;
          if (int'(hb) >= WHEELS) begin
            if (ctx_tick) begin
              state <= S_WALK;
            end else begin
              result_strobe <= 1'b1;
              kind          <= K_ADD_REJ;
              expired_id    <= link_id[4:0];
              last          <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            state <= S_ARM_B;
          end
        end
        S_ARM_B: begin
          if (big) begin
            if (int'(arm_w) + 1 >= WHEELS) begin
              if (ctx_tick) begin
                state <= S_WALK;
              end else begin
                result_strobe <= 1'b1;
                kind          <= K_ADD_REJ;
                expired_id    <= link_id[4:0];
                last          <= 1'b1;
                state         <= S_IDLE;
              end
            end else begin
              arm_w   <= arm_w + 4'd1;
              arm_adj <= adj1;
              state   <= S_ARM_C;
            end
          end else begin
            state <= S_ARM_C;
          end
        end
        S_ARM_C: begin
          link_w    <= arm_w[LW-1:0];
          link_slot <= arm_slot;
          state     <= S_LINK_RD;
        end
        S_LINK_RD: begin
          state <= S_LINK;
        end
        S_LINK: begin
          if (ctx_tick) begin
            state <= S_WALK;
          end else begin
            result_strobe <= 1'b1;
            kind          <= K_ADD_OK;
            expired_id    <= link_id[4:0];
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_DSP_RD: begin
          state <= S_DSP_CLR;
        end
        S_DSP_CLR: begin
          cur   <= s_head;
          steps <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (cur < ID_W'(MAX_TIMERS) && steps < ID_W'(MAX_TIMERS)) begin
            state <= S_WALK_D;
          end else if (lv == '0) begin
            result_strobe <= 1'b1;
            kind          <= K_DONE;
            expired_id    <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            lv    <= lv - 1'b1;
            state <= S_DSP_RD;
          end
        end
        S_WALK_D: begin
          cur     <= nl_rdata;
          steps   <= steps + 1'b1;
          link_id <= cur;
          if (lv == '0) begin
            if (n_rep < ID_W'(MAX_REPORT)) begin
              result_strobe <= 1'b1;
              kind          <= K_EXPIRED;
              expired_id    <= cur[4:0];
              last          <= 1'b0;
              n_rep         <= n_rep + 1'b1;
            end
            if (tm_rep) begin
              arm_delay <= tm_delay;
              arm_rep   <= 1'b1;
              link_tw   <= 1'b1;
              state     <= S_DIV;
            end else begin
              state <= S_WALK;
            end
          end else begin
            link_w    <= lwm;
            link_slot <= casc_slot;
            link_tw   <= 1'b0;
            state     <= S_LINK_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("final result while still busy");

  a_mid_expired: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> kind == K_EXPIRED)
    else $error("non-final result is not an expiry");

  a_rep_cap: assert property (@(posedge clk) disable iff (rst)
    n_rep <= ID_W'(MAX_REPORT))
    else $error("expiry report count overflow");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_TICK |=> busy)
    else $error("tick item did not start a dispatch");

endmodule
